/* sv/matrix_vector_relu_layer_assert.svh */
// Assertion macros shared by the dense layer RTL.
`ifndef MATRIX_VECTOR_RELU_LAYER_ASSERT_SVH
`define MATRIX_VECTOR_RELU_LAYER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/mvr_pkg.sv */
// Types and constants of the dense layer with ReLU.
package mvr_pkg;

   localparam int DataWidth = 16;
   localparam int ProdWidth = 32;
   localparam int AccWidth  = 48;
   localparam int OutWidth  = 47;
   localparam int RowWidth  = 12;
   localparam int ColWidth  = 12;

   localparam logic signed [AccWidth-1:0] ACC_MAX = {1'b0, {(AccWidth-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] ACC_MIN = {1'b1, {(AccWidth-1){1'b0}}};

   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_WEIGHT = 1'b1
   } func_type;

   typedef struct packed {
      func_type                     func;
      logic [RowWidth-1:0]          row_index;
      logic signed [DataWidth-1:0]  value;
      logic                         last_in_column;
      logic                         end_of_matrix;
   } req_type;

   typedef struct packed {
      logic [ColWidth-1:0]  column_index;
      logic [OutWidth-1:0]  activation_out;
      logic                 saturated;
   } rsp_type;

endpackage

/* sv/mvr_if.sv */
// Valid/ready channel interfaces for requests and results of the dense layer.
interface mvr_req_if;
   import mvr_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mvr_rsp_if;
   import mvr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/mvr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mvr_ram #(
   parameter int Width = 16,
   parameter int Depth = 4096,
   parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/matrix_vector_relu_layer.sv */
// Dense layer: streamed matrix-vector multiply-accumulate with ReLU output.
//
//   channel    direction  carries
//   req_chan   in         activation loads and weights, valid/ready
//   rsp_chan   out        column index, ReLU result and clip flag, valid/ready
//
// One request is taken per cycle unless the pipeline stalls. A column's last
// weight passes the store read, the multiply, then the accumulate into the
// output register. The accumulator updates once per cycle on advance and feeds itself.
// Reset clears the pipeline, accumulator and column counter at once; the
// activation store is not cleared. The whole pipeline holds only when a
// column-ending weight reaches the accumulator while an earlier result waits.
module matrix_vector_relu_layer #(
   parameter int VECTOR_DEPTH = 4096,
   parameter int MAX_COLUMNS  = 4096
) (
   input  logic       clock,
   input  logic       reset,
   mvr_req_if.sink    req_chan,
   mvr_rsp_if.source  rsp_chan
);
   import mvr_pkg::*;

   localparam int AddrWidth = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   `include "matrix_vector_relu_layer_assert.svh"

   logic                        advance;
   logic                        stall;
   logic                        accept;
   logic                        in_range;
   logic [16:0]                 row_ext;
   logic [AddrWidth-1:0]        ram_addr;
   logic [DataWidth-1:0]        ram_rd_data;
   logic                        ram_wr_en;

   logic                        p1_valid_ff, p1_valid_in;
   logic signed [DataWidth-1:0] p1_weight_ff;
   logic                        p1_hit_ff;
   logic                        p1_last_ff;
   logic                        p1_end_ff;

   logic signed [DataWidth-1:0] x_value;
   logic signed [ProdWidth-1:0] product;

   logic                        p2_valid_ff;
   logic signed [ProdWidth-1:0] p2_prod_ff;
   logic                        p2_last_ff;
   logic                        p2_end_ff;

   logic signed [AccWidth-1:0]  acc_ff;
   logic                        clip_ff;
   logic signed [AccWidth:0]    sum;
   logic signed [AccWidth-1:0]  acc_in;
   logic                        clip_in;
   logic                        overflow;

   logic [ColWidth-1:0]         col_ff;
   logic [16:0]                 col_inc;
   logic [ColWidth-1:0]         col_next;

   logic                        out_valid_ff;
   rsp_type                     out_data_ff;
   logic                        emit;

   // A held column-ending weight is the only thing that stops the pipeline.
   assign stall   = p2_valid_ff & p2_last_ff & out_valid_ff & ~rsp_chan.ready;
   assign advance = ~stall;
   assign req_chan.ready = advance;
   assign accept  = req_chan.valid & advance;

   assign row_ext  = 17'(req_chan.payload.row_index);
   assign in_range = row_ext < 17'(VECTOR_DEPTH);
   assign ram_addr = row_ext[AddrWidth-1:0];
   assign ram_wr_en = accept & (req_chan.payload.func == FUNC_LOAD) & in_range;

   mvr_ram #(
      .Width (DataWidth),
      .Depth (VECTOR_DEPTH)
   ) u_vector_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_chan.payload.value),
      .rd_en   (accept),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   assign p1_valid_in = accept & (req_chan.payload.func == FUNC_WEIGHT);

   // A weight beyond the store multiplies zero.
   assign x_value = p1_hit_ff ? signed'(ram_rd_data) : '0;
   assign product = x_value * p1_weight_ff;

   assign sum      = (AccWidth+1)'(acc_ff) + (AccWidth+1)'(p2_prod_ff);
   assign overflow = sum[AccWidth] != sum[AccWidth-1];

   always_comb begin
      if (overflow) begin
         acc_in = sum[AccWidth] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = sum[AccWidth-1:0];
      end
   end

   assign clip_in = clip_ff | overflow;
   assign emit    = advance & p2_valid_ff & p2_last_ff;

   assign col_inc  = 17'(col_ff) + 17'd1;
   assign col_next = (col_inc >= 17'(MAX_COLUMNS)) ? '0 : col_inc[ColWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            p1_valid_ff  <= p1_valid_in;
            p1_weight_ff <= req_chan.payload.value;
            p1_hit_ff    <= in_range;
            p1_last_ff   <= req_chan.payload.last_in_column;
            p1_end_ff    <= req_chan.payload.end_of_matrix;

            p2_valid_ff <= p1_valid_ff;
            p2_prod_ff  <= product;
            p2_last_ff  <= p1_last_ff;
            p2_end_ff   <= p1_end_ff;

            if (p2_valid_ff) begin
               if (p2_last_ff) begin
                  acc_ff  <= '0;
                  clip_ff <= 1'b0;
                  col_ff  <= p2_end_ff ? '0 : col_next;
               end else begin
                  acc_ff  <= acc_in;
                  clip_ff <= clip_in;
               end
            end
         end

         if (emit) begin
            out_valid_ff                <= 1'b1;
            out_data_ff.column_index    <= col_ff;
            out_data_ff.activation_out  <= acc_in[AccWidth-1] ? '0 : acc_in[OutWidth-1:0];
            out_data_ff.saturated       <= clip_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   `MVR_ASSERT_NEXT(a_column_clears_acc, clock, reset, emit, (acc_ff == '0) && !clip_ff, "accumulator not cleared after a column result")
   `MVR_ASSERT_SAME(a_result_from_last, clock, reset, $rose(out_valid_ff), $past(p2_valid_ff && p2_last_ff), "result appeared without a column-ending weight")
   `MVR_ASSERT_SAME(a_column_in_bounds, clock, reset, MAX_COLUMNS <= 4096, 17'(col_ff) < 17'(MAX_COLUMNS), "column counter beyond its limit")

endmodule
